[rtl/sparse_polynomial_add_merge_macros.svh]
// ----------------------------------------------------------------------------
// Sparse polynomial add/merge assertion macros
// Clocked assertion helpers for the RTL of the block, used by the controller.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_ADD_MERGE_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADD_MERGE_MACROS_SVH

// Checked on every clock edge outside reset.
`define SPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SPA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/spa_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial add/merge package
// Field widths, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int COEF_W  = 16;
  localparam int EXP_W   = 8;
  localparam int SUM_W   = 17;
  localparam int ENTRY_W = COEF_W + EXP_W;

  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE    = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic a_more;
    logic b_more;
    logic last;
  } dp_sts_t;

endpackage

[rtl/sparse_polynomial_add_merge.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial add/merge
// Loads two term lists and emits their sum as a merged term stream.
// ----------------------------------------------------------------------------
// An append transaction (cmd 0 or 1) writes the term into the first or
// second term store; appends past MAX_TERMS are dropped. A merge transaction
// (cmd 2) walks both stores and emits one result per distinct exponent, or a
// single result with out_term_valid low for an empty sum. Each result takes a
// registered read of each store's single read port (prime state), then a
// compare, add and register of the result (step state), which stalls while
// the output register holds a result that out_ready has not taken. Once the
// last result is registered the next transaction is accepted, even while it
// still waits in the output register. Both counts clear at that point.
module sparse_polynomial_add_merge #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spa_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spa_pkg::EXP_W-1:0]         in_exponent,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spa_pkg::SUM_W-1:0]  out_sum_coefficient,
  output logic [spa_pkg::EXP_W-1:0]         out_sum_exponent,
  output logic                              out_term_valid,
  output logic                              out_last_term
);

  spa_pkg::dp_cmd_t cmd;
  spa_pkg::dp_sts_t sts;

  spa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  spa_datapath #(.MAX_TERMS(MAX_TERMS)) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_coefficient      (in_coefficient),
    .in_exponent         (in_exponent),
    .out_sum_coefficient (out_sum_coefficient),
    .out_sum_exponent    (out_sum_exponent),
    .out_term_valid      (out_term_valid),
    .out_last_term       (out_last_term)
  );

endmodule

[rtl/spa_ram.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial add/merge term RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/spa_datapath.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial add/merge datapath
// Term stores, counts, merge indexes, head compare/add and the result register.
// ----------------------------------------------------------------------------
module spa_datapath #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spa_pkg::dp_cmd_t                  cmd,
  output spa_pkg::dp_sts_t                  sts,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic [spa_pkg::EXP_W-1:0]         in_exponent,
  output logic signed [spa_pkg::SUM_W-1:0]  out_sum_coefficient,
  output logic [spa_pkg::EXP_W-1:0]         out_sum_exponent,
  output logic                              out_term_valid,
  output logic                              out_last_term
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_TERMS);

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] i_adv, j_adv;
  logic          we_a, we_b;
  logic [spa_pkg::ENTRY_W-1:0] wdata, rdata_a, rdata_b;
  logic signed [spa_pkg::COEF_W-1:0] ca, cb;
  logic [spa_pkg::EXP_W-1:0] ea, eb;
  logic take_a, take_b;
  logic signed [spa_pkg::SUM_W-1:0] ta, tb, sum;
  logic signed [spa_pkg::SUM_W-1:0] coef_r;
  logic [spa_pkg::EXP_W-1:0] exp_r;
  logic valid_r, last_r;

  assign we_a  = cmd.load_a && (cnt_a_r < CAP);
  assign we_b  = cmd.load_b && (cnt_b_r < CAP);
  assign wdata = {in_coefficient, in_exponent};

  spa_ram #(.WIDTH(spa_pkg::ENTRY_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (wdata),
    .raddr (i_r[AW-1:0]),
    .rdata (rdata_a)
  );

  spa_ram #(.WIDTH(spa_pkg::ENTRY_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (wdata),
    .raddr (j_r[AW-1:0]),
    .rdata (rdata_b)
  );

  assign ca = rdata_a[spa_pkg::ENTRY_W-1:spa_pkg::EXP_W];
  assign ea = rdata_a[spa_pkg::EXP_W-1:0];
  assign cb = rdata_b[spa_pkg::ENTRY_W-1:spa_pkg::EXP_W];
  assign eb = rdata_b[spa_pkg::EXP_W-1:0];

  always_comb begin
    sts.a_more = i_r < cnt_a_r;
    sts.b_more = j_r < cnt_b_r;
    take_a = sts.a_more && (!sts.b_more || (ea >= eb));
    take_b = sts.b_more && (!sts.a_more || (eb >= ea));
    ta = take_a ? {ca[spa_pkg::COEF_W-1], ca} : '0;
    tb = take_b ? {cb[spa_pkg::COEF_W-1], cb} : '0;
    sum = ta + tb;
    i_adv = i_r + CW'(take_a);
    j_adv = j_r + CW'(take_b);
    sts.last = (i_adv >= cnt_a_r) && (j_adv >= cnt_b_r);
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    i_nxt = i_r;
    j_nxt = j_r;
    if (we_a) begin
      cnt_a_nxt = cnt_a_r + CW'(1);
    end
    if (we_b) begin
      cnt_b_nxt = cnt_b_r + CW'(1);
    end
    if (cmd.start) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.step) begin
      i_nxt = i_adv;
      j_nxt = j_adv;
      if (sts.last) begin
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      coef_r  <= sum;
      exp_r   <= take_a ? ea : (take_b ? eb : '0);
      valid_r <= take_a || take_b;
      last_r  <= sts.last;
    end
  end

  assign out_sum_coefficient = coef_r;
  assign out_sum_exponent    = exp_r;
  assign out_term_valid      = valid_r;
  assign out_last_term       = last_r;

endmodule

[rtl/spa_ctrl.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial add/merge controller
// Sequences loads and the merge walk, and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_add_merge_macros.svh"

module spa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [spa_pkg::CMD_W-1:0]  in_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output spa_pkg::dp_cmd_t           cmd,
  input  spa_pkg::dp_sts_t           sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc, slot_free;

  always_comb begin
    in_ready   = state_r == S_IDLE;
    acc        = in_valid && in_ready;
    slot_free  = !out_valid_r || out_ready;
    cmd.load_a = acc && (in_cmd == spa_pkg::CMD_APPEND_A);
    cmd.load_b = acc && (in_cmd == spa_pkg::CMD_APPEND_B);
    cmd.start  = acc && (in_cmd == spa_pkg::CMD_MERGE);
    cmd.step   = (state_r == S_STEP) && slot_free;

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (cmd.step) begin
          state_nxt = sts.last ? S_IDLE : S_PRIME;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SPA_ASSERT(a_step_slot_free, (cmd.step |-> (!out_valid_r || out_ready)), "step into busy result")
  `SPA_ASSERT(a_merge_primes, (cmd.start |=> (state_r == S_PRIME)), "merge did not start walk")
  `SPA_ASSERT(a_last_ends_run, ((cmd.step && sts.last) |=> ((state_r == S_IDLE) && out_valid_r)), "last term did not end run")
  `SPA_ASSERT(a_empty_is_last, (((state_r == S_STEP) && !sts.a_more && !sts.b_more) |-> sts.last), "exhausted lists not last")

endmodule
